### design/small_strain_accumulator_assert.svh
// Assertion macros shared by the small strain accumulator modules.
`ifndef SMALL_STRAIN_ACCUMULATOR_ASSERT_SVH
`define SMALL_STRAIN_ACCUMULATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SSA_ASSERT(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define SSA_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

### design/ssa_pkg.sv
// Shared constants, types and helper functions of the small strain accumulator.
package ssa_pkg;

  // Default arithmetic widths.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ACC_WIDTH_DEF  = 48;
  localparam int FRAC_BITS      = 16;
  localparam int OUT_WIDTH      = 48;

  // Tensor components and the products that feed them.
  localparam int NUM_TERMS = 6;
  localparam int NUM_PROD  = 9;
  localparam int NUM_AXES  = 3;

  localparam int IDX_XX = 0;
  localparam int IDX_YY = 1;
  localparam int IDX_ZZ = 2;
  localparam int IDX_XY = 3;
  localparam int IDX_YZ = 4;
  localparam int IDX_XZ = 5;

  // Products in order: dx*ux, dy*uy, dz*uz, then the shear pairs
  // (dy*ux, dx*uy), (dz*uy, dy*uz), (dz*ux, dx*uz).
  localparam int PROD_DERIV [NUM_PROD] = '{0, 1, 2, 1, 0, 2, 1, 2, 0};
  localparam int PROD_DISP  [NUM_PROD] = '{0, 1, 2, 0, 1, 1, 2, 0, 2};

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [APB_ADDR_W-3:0] REG_DIMENSION = '0;

  // Dimension codes; the zero code behaves as 3D.
  localparam int DIM_W = 2;
  typedef logic [DIM_W-1:0] dim_t;
  localparam dim_t DIM_ZERO = 2'd0;
  localparam dim_t DIM_1D   = 2'd1;
  localparam dim_t DIM_2D   = 2'd2;
  localparam dim_t DIM_3D   = 2'd3;

  // Control that travels with each item through the queue.
  typedef struct packed {
    logic                 last;
    dim_t                 dim;
    logic [NUM_TERMS-1:0] sat;
  } item_ctl_t;

  // Components that a dimension updates and emits.
  function automatic logic [NUM_TERMS-1:0] comp_used(input dim_t dim);
    logic [NUM_TERMS-1:0] used;
    logic two_d;
    logic three_d;
    two_d   = (dim != DIM_1D);
    three_d = (dim == DIM_3D) || (dim == DIM_ZERO);
    used         = '0;
    used[IDX_XX] = 1'b1;
    used[IDX_YY] = two_d;
    used[IDX_XY] = two_d;
    used[IDX_ZZ] = three_d;
    used[IDX_YZ] = three_d;
    used[IDX_XZ] = three_d;
    return used;
  endfunction

endpackage

### design/small_strain_accumulator.sv
// Top level of the small strain accumulator: configuration register and the three parts.
//
// Usage: each transfer on the s_ channel carries one basis function of a
// quadrature point: three derivatives and three displacement components in
// signed Q16.16, with s_tlast marking the last basis of the point. The block
// accumulates the small-strain tensor over the point and, for the item marked
// last, sends one transfer on the m_ channel with the six Q32.16 components
// and a saturation flag in m_tuser. The dimension register at address 0
// selects 1D, 2D or 3D; the user must write it only between points, as the
// block does not enforce this. Throughput is one item per cycle while s_tready
// is high, set by the product pipeline: nine split multiplies in one stage and
// their recombination in the next; results then pass the queue and output register.
// When the receiver stalls, results wait in the output register while items
// keep flowing into a four-entry queue; once that fills, s_tready drops.
// Reset sets the dimension to 3D, clears the sums, the flag and the queue,
// and leaves both channels idle; there is no clearing pass.
module small_strain_accumulator import ssa_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  localparam int IN_TDATA_W = ((2 * NUM_AXES * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W = NUM_TERMS * OUT_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // Input stream.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // deriv_x, deriv_y, deriv_z, disp_x, disp_y, disp_z, from the lowest bit up
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // last_basis
  input  logic                   s_tlast,
  // Result stream.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // strain_xx, strain_yy, strain_zz, strain_xy, strain_yz, strain_xz, lowest bit up
  output logic [OUT_TDATA_W-1:0] m_tdata,
  // saturated
  output logic                   m_tuser,
  // Configuration port.
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_ADDR_W-1:0]  paddr,
  input  logic [APB_DATA_W-1:0]  pwdata,
  output logic [APB_DATA_W-1:0]  prdata,
  output logic                   pready
);

  localparam int QW = NUM_TERMS * ACC_WIDTH + $bits(item_ctl_t);

  dim_t                           dimension;
  logic                           push;
  logic                           push_ready;
  logic [NUM_TERMS*ACC_WIDTH-1:0] push_terms;
  item_ctl_t                      push_ctl;
  logic                           q_valid;
  logic                           q_pop;
  logic [QW-1:0]                  q_data;
  item_ctl_t                      q_ctl;
  logic                           cfg_write;
  logic                           sel_dimension;

  // Register access.
  assign pready        = 1'b1;
  assign sel_dimension = (paddr[APB_ADDR_W-1:2] == REG_DIMENSION);
  assign cfg_write     = psel && penable && pwrite && pready;
  assign prdata        = sel_dimension ? APB_DATA_W'(dimension) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_3D;
    end else if (cfg_write && sel_dimension) begin
      dimension <= pwdata[DIM_W-1:0];
    end
  end

  ssa_front #(
    .DATA_WIDTH (DATA_WIDTH),
    .ACC_WIDTH  (ACC_WIDTH),
    .TDATA_W    (IN_TDATA_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .in_last    (s_tlast),
    .dimension  (dimension),
    .push       (push),
    .push_ready (push_ready),
    .push_terms (push_terms),
    .push_ctl   (push_ctl)
  );

  ssa_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  ({push_ctl, push_terms}),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  assign q_ctl = q_data[QW-1:NUM_TERMS*ACC_WIDTH];

  ssa_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_terms  (q_data[NUM_TERMS*ACC_WIDTH-1:0]),
    .q_ctl    (q_ctl),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

### design/ssa_front.sv
// Front end: accepts basis items, forms the scaled products and shear terms.
module ssa_front import ssa_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int ACC_WIDTH  = ACC_WIDTH_DEF,
  parameter int TDATA_W    = ((2 * NUM_AXES * DATA_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [TDATA_W-1:0]             in_data,
  input  logic                           in_last,
  input  dim_t                           dimension,
  output logic                           push,
  input  logic                           push_ready,
  output logic [NUM_TERMS*ACC_WIDTH-1:0] push_terms,
  output item_ctl_t                      push_ctl
);

  localparam int LO_W   = DATA_WIDTH / 2;
  localparam int HI_W   = DATA_WIDTH - LO_W;
  localparam int PLO_W  = DATA_WIDTH + LO_W + 1;
  localparam int PHI_W  = DATA_WIDTH + HI_W;
  localparam int PW     = 2 * DATA_WIDTH;
  localparam int EW     = ((PW > ACC_WIDTH) ? PW : ACC_WIDTH) + 1;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic                        en;
  logic                        v1;
  logic                        v2;
  logic                        last1;
  logic                        last2;
  dim_t                        dim1;
  dim_t                        dim2;
  logic signed [PLO_W-1:0]     p_lo [NUM_PROD];
  logic signed [PHI_W-1:0]     p_hi [NUM_PROD];
  logic signed [PW-1:0]        prod [NUM_PROD];
  logic [ACC_WIDTH-1:0]        prod_term [NUM_PROD];
  logic [NUM_PROD-1:0]         prod_sat;
  logic [ACC_WIDTH-1:0]        comp [NUM_TERMS];
  logic [NUM_TERMS-1:0]        comp_sat;

  // The pipeline moves as a whole unless its last stage cannot enter the queue.
  assign en       = !v2 || push_ready;
  assign in_ready = en;
  assign push     = v2 && push_ready;

  // Valid bits of the two product stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Item control follows the products; the dimension is sampled on transfer.
  always_ff @(posedge clk) begin
    if (en) begin
      last1 <= in_last;
      dim1  <= dimension;
      last2 <= last1;
      dim2  <= dim1;
    end
  end

  // Each product is split into two half-width multiplies, then recombined.
  for (genvar k = 0; k < NUM_PROD; k++) begin : g_prod
    logic signed [DATA_WIDTH-1:0] op_a;
    logic signed [DATA_WIDTH-1:0] op_b;
    logic signed [PW-1:0]         shifted;
    logic signed [EW-1:0]         ext;
    logic                         over_hi;
    logic                         over_lo;

    assign op_a = in_data[PROD_DERIV[k]*DATA_WIDTH +: DATA_WIDTH];
    assign op_b = in_data[(NUM_AXES + PROD_DISP[k])*DATA_WIDTH +: DATA_WIDTH];

    // Stage one: partial products against the low and high halves.
    always_ff @(posedge clk) begin
      if (en) begin
        p_lo[k] <= op_a * $signed({1'b0, op_b[LO_W-1:0]});
        p_hi[k] <= op_a * $signed(op_b[DATA_WIDTH-1:LO_W]);
      end
    end

    // Stage two: the full product.
    always_ff @(posedge clk) begin
      if (en) begin
        prod[k] <= (PW'(p_hi[k]) <<< LO_W) + PW'(p_lo[k]);
      end
    end

    // Drop the fraction with rounding toward minus infinity, then clamp.
    assign shifted      = prod[k] >>> FRAC_BITS;
    assign ext          = EW'(shifted);
    assign over_hi      = ext > EW'($signed(ACC_MAX));
    assign over_lo      = ext < EW'($signed(ACC_MIN));
    assign prod_sat[k]  = over_hi || over_lo;
    assign prod_term[k] = over_hi ? ACC_MAX : (over_lo ? ACC_MIN : ext[ACC_WIDTH-1:0]);
  end

  // Normal terms pass through; a shear term is the floor of half the pair sum.
  always_comb begin
    logic signed [ACC_WIDTH:0] pair;
    comp[IDX_XX]     = prod_term[0];
    comp[IDX_YY]     = prod_term[1];
    comp[IDX_ZZ]     = prod_term[2];
    comp_sat[IDX_XX] = prod_sat[0];
    comp_sat[IDX_YY] = prod_sat[1];
    comp_sat[IDX_ZZ] = prod_sat[2];
    for (int j = 0; j < NUM_AXES; j++) begin
      pair = (ACC_WIDTH + 1)'($signed(prod_term[NUM_AXES + 2*j]))
           + (ACC_WIDTH + 1)'($signed(prod_term[NUM_AXES + 2*j + 1]));
      comp[IDX_XY + j]     = pair[ACC_WIDTH:1];
      comp_sat[IDX_XY + j] = prod_sat[NUM_AXES + 2*j] || prod_sat[NUM_AXES + 2*j + 1];
    end
  end

  // Pack the terms and control for the queue.
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      push_terms[i*ACC_WIDTH +: ACC_WIDTH] = comp[i];
    end
    push_ctl.last = last2;
    push_ctl.dim  = dim2;
    push_ctl.sat  = comp_sat;
  end

endmodule

### design/ssa_fifo.sv
// Short register queue between the front end and the accumulator.
`include "small_strain_accumulator_assert.svh"

module ssa_fifo import ssa_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];

  // Storage holds payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `SSA_ASSERT(a_no_overflow, clk, rst, !(push && (count == CNT_W'(DEPTH))), "queue write while full")
  `SSA_ASSERT(a_no_underflow, clk, rst, !(pop && (count == '0)), "queue read while empty")

endmodule

### design/ssa_back.sv
// Back end: saturating accumulation of the strain terms and the result register.
`include "small_strain_accumulator_assert.svh"

module ssa_back import ssa_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  output logic                           q_pop,
  input  logic [NUM_TERMS*ACC_WIDTH-1:0] q_terms,
  input  item_ctl_t                      q_ctl,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [NUM_TERMS*OUT_WIDTH-1:0] m_tdata,
  output logic                           m_tuser
);

  localparam int MW = (ACC_WIDTH > OUT_WIDTH) ? ACC_WIDTH : OUT_WIDTH;
  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic [ACC_WIDTH-1:0] sums      [NUM_TERMS];
  logic [ACC_WIDTH-1:0] sums_next [NUM_TERMS];
  logic [NUM_TERMS-1:0] used;
  logic [NUM_TERMS-1:0] acc_sat;
  logic                 seen;
  logic                 seen_next;
  logic                 sums_zero;

  // A last item needs the result register free or being freed.
  assign q_pop = q_valid && (!q_ctl.last || !m_tvalid || m_tready);
  assign used  = comp_used(q_ctl.dim);

  // One saturating add per component.
  always_comb begin
    logic [ACC_WIDTH:0] s;
    logic               ovf;
    for (int i = 0; i < NUM_TERMS; i++) begin
      s = (ACC_WIDTH + 1)'($signed(sums[i]))
        + (ACC_WIDTH + 1)'($signed(q_terms[i*ACC_WIDTH +: ACC_WIDTH]));
      ovf        = (s[ACC_WIDTH] != s[ACC_WIDTH-1]);
      acc_sat[i] = ovf;
      if (!used[i]) begin
        sums_next[i] = sums[i];
      end else if (ovf) begin
        sums_next[i] = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
        sums_next[i] = s[ACC_WIDTH-1:0];
      end
    end
    seen_next = seen || (|(used & (acc_sat | q_ctl.sat)));
  end

  // Running sums; a last item clears them as its result enters the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        sums[i] <= '0;
      end
      seen <= 1'b0;
    end else if (q_pop) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        sums[i] <= q_ctl.last ? '0 : sums_next[i];
      end
      seen <= q_ctl.last ? 1'b0 : seen_next;
    end
  end

  // Result register valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop && q_ctl.last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Result payload, unused components forced to zero.
  always_ff @(posedge clk) begin
    logic [MW-1:0] ext;
    if (q_pop && q_ctl.last) begin
      for (int i = 0; i < NUM_TERMS; i++) begin
        ext = MW'($signed(sums_next[i]));
        m_tdata[i*OUT_WIDTH +: OUT_WIDTH] <= used[i] ? ext[OUT_WIDTH-1:0] : '0;
      end
      m_tuser <= seen_next;
    end
  end

  always_comb begin
    sums_zero = !seen;
    for (int i = 0; i < NUM_TERMS; i++) begin
      sums_zero = sums_zero && (sums[i] == '0);
    end
  end

  `SSA_ASSERT(a_no_result_overrun, clk, rst, !(q_pop && q_ctl.last && m_tvalid && !m_tready), "result overwritten while stalled")
  `SSA_ASSERT_NEXT(a_clear_after_last, clk, rst, q_pop && q_ctl.last, sums_zero, "sums not cleared after last item")

endmodule

### test/tb_top.sv
// Self-checking testbench of the small strain accumulator with its own strain predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssa_pkg::*;

  localparam int IN_W  = ((2 * NUM_AXES * DATA_WIDTH_DEF + 7) / 8) * 8;
  localparam int RES_W = NUM_TERMS * OUT_WIDTH;
  localparam longint ACC_MAX = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint ACC_MIN = -ACC_MAX - 1;
  localparam logic [APB_ADDR_W-1:0] DIMENSION_ADDR = {REG_DIMENSION, 2'b00};
  localparam int RANDOM_ITEMS  = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 250;
  localparam int MAX_GAP       = 11;

  typedef logic signed [DATA_WIDTH_DEF-1:0] q16_t;

  localparam q16_t Q_MAX = 32'sh7fff_ffff;
  localparam q16_t Q_MIN = 32'sh8000_0000;
  localparam q16_t Q_ONE = 32'sh0001_0000;

  // Fields of one basis function, deriv_x in the lowest bits.
  typedef struct packed {
    q16_t disp_z;
    q16_t disp_y;
    q16_t disp_x;
    q16_t deriv_z;
    q16_t deriv_y;
    q16_t deriv_x;
  } basis_data_t;

  typedef struct packed {
    logic        last_basis;
    basis_data_t data;
  } basis_item_t;

  // One quadrature point result: six strain components and the saturation flag.
  typedef struct packed {
    logic                                sat;
    logic [NUM_TERMS-1:0][OUT_WIDTH-1:0] comp;
  } strain_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_W-1:0]       s_tdata  = '0;
  logic                  s_tlast  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [RES_W-1:0]      m_tdata;
  logic                  m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  // Predictor state and the results it still waits for.
  longint      strain_sum [NUM_TERMS];
  logic        sat_seen      = 1'b0;
  dim_t        cfg_dimension = DIM_3D;
  strain_t     expected_strain [$];
  basis_item_t pending_basis [$];
  string       comp_name [NUM_TERMS] = '{"xx", "yy", "zz", "xy", "yz", "xz"};

  // Pacing controls, written by the stimulus process only.
  bit tx_gaps     = 1'b0;
  bit rx_gaps     = 1'b0;
  int hold_req_id = 0;
  int hold_len    = 0;

  int error_count  = 0;
  int random_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  small_strain_accumulator u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    foreach (strain_sum[i]) strain_sum[i] = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // Product of two Q16.16 values, floored back to Q.16 and clamped to the sum width.
  function automatic longint scaled_product(input q16_t a, input q16_t b);
    longint p;
    p = (longint'(a) * longint'(b)) >>> FRAC_BITS;
    if (p > ACC_MAX) begin
      p = ACC_MAX;
      sat_seen = 1'b1;
    end else if (p < ACC_MIN) begin
      p = ACC_MIN;
      sat_seen = 1'b1;
    end
    return p;
  endfunction

  // Shear contribution: half the sum of the two cross products, floored.
  function automatic longint shear_half(input longint p1, input longint p2);
    return (p1 + p2) >>> 1;
  endfunction

  function automatic void add_to_sum(input int idx, input longint term);
    longint s;
    s = strain_sum[idx] + term;
    if (s > ACC_MAX) begin
      s = ACC_MAX;
      sat_seen = 1'b1;
    end else if (s < ACC_MIN) begin
      s = ACC_MIN;
      sat_seen = 1'b1;
    end
    strain_sum[idx] = s;
  endfunction

  // Accumulate one accepted basis function; the last one of a point closes it.
  function automatic void predict_basis(input basis_item_t it);
    strain_t r;
    logic    uses_2d;
    logic    uses_3d;
    logic    emit;
    uses_2d = (cfg_dimension != DIM_1D);
    uses_3d = (cfg_dimension == DIM_3D) || (cfg_dimension == DIM_ZERO);
    add_to_sum(IDX_XX, scaled_product(it.data.deriv_x, it.data.disp_x));
    if (uses_2d) begin
      add_to_sum(IDX_YY, scaled_product(it.data.deriv_y, it.data.disp_y));
      add_to_sum(IDX_XY, shear_half(scaled_product(it.data.deriv_y, it.data.disp_x),
                                    scaled_product(it.data.deriv_x, it.data.disp_y)));
    end
    if (uses_3d) begin
      add_to_sum(IDX_ZZ, scaled_product(it.data.deriv_z, it.data.disp_z));
      add_to_sum(IDX_YZ, shear_half(scaled_product(it.data.deriv_z, it.data.disp_y),
                                    scaled_product(it.data.deriv_y, it.data.disp_z)));
      add_to_sum(IDX_XZ, shear_half(scaled_product(it.data.deriv_z, it.data.disp_x),
                                    scaled_product(it.data.deriv_x, it.data.disp_z)));
    end
    if (it.last_basis) begin
      r.sat = sat_seen;
      for (int i = 0; i < NUM_TERMS; i++) begin
        emit = (i == IDX_XX) || uses_3d || (uses_2d && (i == IDX_YY || i == IDX_XY));
        r.comp[i] = emit ? strain_sum[i][OUT_WIDTH-1:0] : '0;
        strain_sum[i] = 0;
      end
      sat_seen = 1'b0;
      expected_strain.push_back(r);
    end
  endfunction

  // Input side: one item per transfer, with an optional gap drawn after each item.
  basis_item_t drv_item;
  int          tx_wait = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_basis(drv_item);
      end
      if (s_tvalid && !s_tready) begin
        // Hold the offered item until it is taken.
      end else if (tx_wait > 0) begin
        tx_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_basis.size() != 0) begin
        drv_item = pending_basis.pop_front();
        s_tdata  <= drv_item.data;
        s_tlast  <= drv_item.last_basis;
        s_tvalid <= 1'b1;
        tx_wait = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Result side: compare each transfer with the oldest prediction and pace m_tready.
  int rx_wait     = 0;
  int hold_left   = 0;
  int hold_ack_id = 0;

  always @(posedge clk) begin
    strain_t want;
    if (rst) begin
      m_tready <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_strain.size() == 0) begin
          report_mismatch("result transfer with no prediction waiting");
        end else begin
          want = expected_strain.pop_front();
          for (int i = 0; i < NUM_TERMS; i++) begin
            if (m_tdata[i*OUT_WIDTH +: OUT_WIDTH] !== want.comp[i]) begin
              report_mismatch($sformatf("strain_%s got %h want %h", comp_name[i],
                                        m_tdata[i*OUT_WIDTH +: OUT_WIDTH], want.comp[i]));
            end
          end
          if (m_tuser !== want.sat) begin
            report_mismatch($sformatf("saturated got %b want %b", m_tuser, want.sat));
          end
        end
        rx_wait = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      // A long hold requested by the stimulus is counted down here.
      if (hold_ack_id != hold_req_id) begin
        hold_left   = hold_len;
        hold_ack_id = hold_req_id;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      m_tready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // Wait until every item is taken and every result is in, then let the pipe settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_basis.size() != 0 || s_tvalid || expected_strain.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic read_dimension(input dim_t want);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DIMENSION_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    if (prdata !== {{(APB_DATA_W-DIM_W){1'b0}}, want}) begin
      report_mismatch($sformatf("dimension reads %h want %h", prdata, want));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Register write while idle; the upper bits of the word are random.
  task automatic write_dimension(input dim_t dim);
    logic [APB_DATA_W-1:0] word;
    wait_idle();
    word = $urandom;
    word[DIM_W-1:0] = dim;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DIMENSION_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_dimension = dim;
    read_dimension(dim);
  endtask

  task automatic add_basis(input q16_t dx, input q16_t dy, input q16_t dz,
                           input q16_t ux, input q16_t uy, input q16_t uz,
                           input logic last_basis);
    basis_item_t it;
    it.data       = '{disp_z: uz, disp_y: uy, disp_x: ux,
                      deriv_z: dz, deriv_y: dy, deriv_x: dx};
    it.last_basis = last_basis;
    pending_basis.push_back(it);
  endtask

  // Moderate and small values so that sums stay in range, mixed with full-range and extreme ones.
  function automatic q16_t random_q16();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return q16_t'(int'($urandom_range(0, 2097152)) - 1048576);
      4, 5, 6:    return q16_t'($urandom);
      7:          return Q_MIN;
      8:          return Q_MAX;
      default:    return q16_t'(int'($urandom_range(0, 2)) - 1);
    endcase
  endfunction

  task automatic add_random_point(input int len, input bit closed);
    for (int i = 0; i < len; i++) begin
      add_basis(random_q16(), random_q16(), random_q16(),
                random_q16(), random_q16(), random_q16(),
                closed && (i == len - 1));
      random_count++;
    end
  endtask

  // Stimulus: reset, directed points, then random phases under varying dimension.
  initial begin
    int n_points;
    int phase_no;
    bit hold_phase;
    phase_no = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    read_dimension(DIM_3D);

    // Extremes of every field, each in a point of its own.
    add_basis(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
    add_basis(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    add_basis(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b1);
    // Products below one LSB: flooring of negatives and odd shear pairs.
    add_basis(1, -1, 1, 1, 1, -1, 1'b1);
    add_basis(0, 0, 0, 0, 0, 0, 1'b1);
    // Positive saturation over a point, then a clean point that clears the flag.
    repeat (2) add_basis(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b0);
    add_basis(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 1'b1);
    add_basis(Q_ONE, -Q_ONE, 3, Q_ONE, 5, -Q_ONE, 1'b0);
    add_basis(-Q_ONE, Q_ONE, -7, 3, Q_ONE, Q_ONE, 1'b1);
    // Negative saturation.
    repeat (2) add_basis(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b0);
    add_basis(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, 1'b1);

    // Lower dimensions ignore the unused axes; the zero code acts as 3D.
    write_dimension(DIM_1D);
    add_basis(Q_ONE, Q_MAX, Q_MAX, Q_ONE, Q_MAX, Q_MAX, 1'b0);
    add_basis(-Q_ONE, Q_MIN, Q_MIN, Q_ONE, Q_MIN, Q_MIN, 1'b1);
    write_dimension(DIM_2D);
    add_basis(Q_ONE, -Q_ONE, Q_MAX, 2, Q_ONE, Q_MAX, 1'b0);
    add_basis(Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 1'b1);
    write_dimension(DIM_ZERO);
    add_basis(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1);

    // Dimension changes inside an open point.
    write_dimension(DIM_3D);
    add_basis(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b0);
    add_basis(Q_MAX, -Q_ONE, Q_ONE, 9, -Q_ONE, Q_MIN, 1'b0);
    write_dimension(DIM_1D);
    add_basis(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 1'b1);
    write_dimension(DIM_2D);
    add_basis(Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, -Q_ONE, 1'b0);
    add_basis(-1, Q_MAX, Q_MIN, Q_ONE, 1, Q_MAX, 1'b0);
    write_dimension(DIM_3D);
    add_basis(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, -Q_ONE, Q_ONE, 1'b1);

    // Random phases; each ends with the pipe drained, sometimes inside a point.
    while (random_count < RANDOM_ITEMS) begin
      phase_no++;
      hold_phase = (phase_no == 3);
      write_dimension(dim_t'($urandom_range(0, 3)));
      if (hold_phase) begin
        // Receiver stalls for a long stretch while the sender keeps offering.
        tx_gaps  = 1'b0;
        rx_gaps  = 1'b0;
        hold_len = LONG_HOLD;
        hold_req_id++;
        for (int p = 0; p < 50; p++) add_random_point($urandom_range(1, 2), 1'b1);
      end else begin
        tx_gaps  = ($urandom_range(0, 3) != 0);
        rx_gaps  = ($urandom_range(0, 3) != 0);
        n_points = $urandom_range(5, 30);
        for (int p = 0; p < n_points; p++) begin
          if ($urandom_range(0, 19) == 0) add_random_point($urandom_range(9, 20), 1'b1);
          else add_random_point($urandom_range(1, 6), 1'b1);
        end
        if ($urandom_range(0, 2) == 0) add_random_point($urandom_range(1, 3), 1'b0);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("[small_strain_accumulator] OK");
    end else begin
      $display("[small_strain_accumulator] ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("[small_strain_accumulator] ERROR");
    $finish;
  end

endmodule
